[hw/rtl/tcapq_pkg.sv]
// Package for the two-class arrival priority queue.
// Holds the queue depth, the action and status codes and the payload types.
// It depends on nothing else.
`default_nettype none

package tcapq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic        registered;
      logic [15:0] minute;
      logic [15:0] tag;
   } entry_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        new_registered;
      logic [15:0] new_minute;
      logic [15:0] new_tag;
   } req_type;

   typedef struct packed {
      logic        head_valid;
      logic        head_registered;
      logic [15:0] head_minute;
      logic [15:0] head_tag;
      logic [4:0]  entry_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type fresh;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/tcapq_cell.sv]
// One cell of the sorted queue chain: it holds one entry and compares it with a new one.
// It takes the new entry or its left neighbor's entry on an insert and its right one's on a pop.
// Depends on tcapq_pkg.
`default_nettype none

module tcapq_cell
   import tcapq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_go,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output logic          go,
   output entry_type     held_entry,
   output entry_type     next_entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      beats;

   always_comb begin
      if (ctrl.fresh.registered != entry_ff.registered) begin
         beats = ctrl.fresh.registered;
      end else begin
         beats = ctrl.fresh.minute < entry_ff.minute;
      end
   end

   assign go = !occupied || beats;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (go) begin
            entry_in = left_go ? left_entry : ctrl.fresh;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign held_entry = entry_ff;
   assign next_entry = entry_in;

endmodule

`default_nettype wire

[hw/rtl/two_class_arrival_priority_queue.sv]
// The queue keeps up to sixteen entries sorted by class, then by arrival minute, with
// equal keys in arrival order, and answers every request with the head, the count and
// a status. A row of cells compares and shifts all entries at once, so one request is
// accepted in every cycle while the response register is free, and the response appears
// in the cycle after acceptance.
// Depends on tcapq_pkg and tcapq_cell.
`default_nettype none

module two_class_arrival_priority_queue
   import tcapq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;
   logic             req_accept;
   logic             is_full;
   logic             is_empty;
   logic [1:0]       status;
   cell_ctrl_type    ctrl;

   logic      go    [QUEUE_DEPTH];
   logic      occ   [QUEUE_DEPTH];
   entry_type held  [QUEUE_DEPTH];
   entry_type nxt   [QUEUE_DEPTH];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign is_empty   = count_ff == '0;

   always_comb begin
      ctrl.insert           = 1'b0;
      ctrl.pop              = 1'b0;
      ctrl.fresh.registered = req_data.new_registered;
      ctrl.fresh.minute     = req_data.new_minute;
      ctrl.fresh.tag        = req_data.new_tag;
      status                = ST_OK;
      count_in              = count_ff;
      case (req_data.action)
         ACT_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = req_accept;
               count_in    = count_ff + 1'b1;
            end
         end
         ACT_POP: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               ctrl.pop = req_accept;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occ[i] = CNT_W'(i) < count_ff;
      if (i == 0) begin : g_first
         tcapq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_go     (1'b0),
            .left_entry  (ctrl.fresh),
            .right_entry (held[i+1]),
            .go          (go[i]),
            .held_entry  (held[i]),
            .next_entry  (nxt[i])
         );
      end else if (i == QUEUE_DEPTH - 1) begin : g_last
         tcapq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_go     (go[i-1]),
            .left_entry  (held[i-1]),
            .right_entry (held[i]),
            .go          (go[i]),
            .held_entry  (held[i]),
            .next_entry  (nxt[i])
         );
      end else begin : g_mid
         tcapq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_go     (go[i-1]),
            .left_entry  (held[i-1]),
            .right_entry (held[i+1]),
            .go          (go[i]),
            .held_entry  (held[i]),
            .next_entry  (nxt[i])
         );
      end
   end

   always_comb begin
      rsp_data_in.head_valid  = count_in != '0;
      rsp_data_in.entry_count = 5'(count_in);
      rsp_data_in.status      = status;
      if (count_in != '0) begin
         rsp_data_in.head_registered = nxt[0].registered;
         rsp_data_in.head_minute     = nxt[0].minute;
         rsp_data_in.head_tag        = nxt[0].tag;
      end else begin
         rsp_data_in.head_registered = 1'b0;
         rsp_data_in.head_minute     = '0;
         rsp_data_in.head_tag        = '0;
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_FULL |->
         rsp_data_ff.entry_count == 5'(QUEUE_DEPTH))
      else $error("A full rejection was reported with a queue that is not full.");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.head_valid == (rsp_data_ff.entry_count != 5'd0))
      else $error("Head valid disagrees with the entry count.");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.action == ACT_INSERT && !is_full |=>
         count_ff == $past(count_ff) + 1'b1)
      else $error("An accepted insert did not raise the entry count.");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff && rsp_data_ff.entry_count == 5'(count_ff))
      else $error("The response does not match the stored count.");
`endif

endmodule

`default_nettype wire

[tb/sv/two_class_arrival_priority_queue_test.sv]
// Self-checking testbench for the two-class arrival priority queue.
// A scoreboard keeps its own sorted copy of the queue and checks every response.
// Depends on tcapq_pkg and two_class_arrival_priority_queue.

module two_class_arrival_priority_queue_test;
   import tcapq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LONG_HOLD = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_ITEMS = 40;
   localparam int PHASE_ITEMS = 100;

   class queue_scoreboard;
      entry_type held[$];
      rsp_type   pending[$];
      int        errors;

      function new();
         errors = 0;
      endfunction

      function void report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endfunction

      function bit ranks_ahead(entry_type cand, entry_type stored);
         if (cand.registered != stored.registered) begin
            return cand.registered;
         end
         return cand.minute < stored.minute;
      endfunction

      function void note_request(req_type r);
         entry_type  fresh;
         rsp_type    want;
         int         pos;
         logic [1:0] status;
         status = ST_OK;
         if (r.action == ACT_INSERT) begin
            if (held.size() >= QUEUE_DEPTH) begin
               status = ST_FULL;
            end else begin
               fresh.registered = r.new_registered;
               fresh.minute = r.new_minute;
               fresh.tag = r.new_tag;
               pos = 0;
               while (pos < held.size() && !ranks_ahead(fresh, held[pos])) begin
                  pos++;
               end
               held.insert(pos, fresh);
            end
         end else if (r.action == ACT_POP) begin
            if (held.size() == 0) begin
               status = ST_EMPTY;
            end else begin
               void'(held.pop_front());
            end
         end
         want = '0;
         if (held.size() > 0) begin
            want.head_valid = 1'b1;
            want.head_registered = held[0].registered;
            want.head_minute = held[0].minute;
            want.head_tag = held[0].tag;
         end
         want.entry_count = 5'(held.size());
         want.status = status;
         pending.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.head_valid !== want.head_valid)
            report_mismatch($sformatf("head_valid got %0h expected %0h",
                                      got.head_valid, want.head_valid));
         if (got.head_registered !== want.head_registered)
            report_mismatch($sformatf("head_registered got %0h expected %0h",
                                      got.head_registered, want.head_registered));
         if (got.head_minute !== want.head_minute)
            report_mismatch($sformatf("head_minute got %0h expected %0h",
                                      got.head_minute, want.head_minute));
         if (got.head_tag !== want.head_tag)
            report_mismatch($sformatf("head_tag got %0h expected %0h",
                                      got.head_tag, want.head_tag));
         if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      got.entry_count, want.entry_count));
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got.status, want.status));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   int holds_asked = 0;
   int holds_served = 0;

   queue_scoreboard sb = new();

   two_class_arrival_priority_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned gap_length(bit allow_zero);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type queue_request(logic [1:0] action, logic registered,
                                             logic [15:0] minute, logic [15:0] tag);
      req_type r;
      r.action = action;
      r.new_registered = registered;
      r.new_minute = minute;
      r.new_tag = tag;
      return r;
   endfunction

   function automatic req_type random_request(int unsigned insert_pct);
      logic [1:0]  action;
      logic [15:0] minute;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) begin
         action = ACT_INSERT;
      end else begin
         case ($urandom_range(0, 9))
            0: action = ACT_QUERY;
            1: action = ACT_UNUSED;
            default: action = ACT_POP;
         endcase
      end
      case ($urandom_range(0, 3))
         0: minute = 16'($urandom_range(0, 3));
         1: minute = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: minute = 16'($urandom);
      endcase
      return queue_request(action, 1'($urandom_range(0, 1)), minute, 16'($urandom));
   endfunction

   task automatic send_request(req_type r);
      int unsigned gap;
      gap = sender_gaps ? gap_length(1'b1) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
      end
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_data);
      end
   end

   initial begin : receiver
      int unsigned span;
      forever begin
         @(posedge clock);
         if (holds_served < holds_asked) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 2) == 0) begin
            span = gap_length(1'b0);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned insert_mix[8] = '{70, 30, 90, 10, 55, 50, 80, 20};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(queue_request(ACT_QUERY, 1'b1, 16'hFFFF, 16'hFFFF));
      send_request(queue_request(ACT_POP, 1'b1, 16'hFFFF, 16'hFFFF));
      send_request(queue_request(ACT_UNUSED, 1'b0, 16'h0000, 16'h0000));
      send_request(queue_request(ACT_INSERT, 1'b0, 16'hFFFF, 16'hFFFF));
      send_request(queue_request(ACT_INSERT, 1'b1, 16'h0000, 16'h0000));
      send_request(queue_request(ACT_INSERT, 1'b1, 16'h0000, 16'h0001));
      send_request(queue_request(ACT_INSERT, 1'b0, 16'hFFFF, 16'h1234));
      send_request(queue_request(ACT_INSERT, 1'b0, 16'h0000, 16'hABCD));
      send_request(queue_request(ACT_UNUSED, 1'b1, 16'h5555, 16'hAAAA));
      for (int i = 0; i < 12; i++) begin
         send_request(queue_request(ACT_INSERT, i[0], 16'(16'h8000 - i),
                                    16'(16'h0100 + i)));
      end
      send_request(queue_request(ACT_INSERT, 1'b1, 16'h0000, 16'hFFFF));
      send_request(queue_request(ACT_POP, 1'b0, 16'h0000, 16'h0000));
      send_request(queue_request(ACT_POP, 1'b0, 16'h0000, 16'h0000));
      send_request(queue_request(ACT_QUERY, 1'b0, 16'h0000, 16'h0000));
      wait_for_results();

      for (int ph = 0; ph < 8; ph++) begin
         sender_gaps = (ph % 3 != 2);
         receiver_stalls = (ph % 4 != 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_request(random_request(insert_mix[ph]));
         end
         if (ph % 2 == 1) begin
            wait_for_results();
         end
         if (ph == 3) begin
            sender_gaps = 1'b0;
            holds_asked++;
            for (int i = 0; i < PRESSURE_ITEMS; i++) begin
               send_request(random_request(60));
            end
            wait_for_results();
         end
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.report_mismatch("responses still outstanding at the end");
      end
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/tcapq_pkg.sv
hw/rtl/tcapq_cell.sv
hw/rtl/two_class_arrival_priority_queue.sv
tb/sv/two_class_arrival_priority_queue_test.sv
